// ===== hw/rtl/rmc_pkg.sv =====
// Package: shared types, command codes and helper functions for the motor command controller.
package rmc_pkg;

  localparam int TIMER_BITS = 16;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [6:0] pct_t;

  localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam pct_t PCT_MAX = 7'd100;

  // Reciprocal of 100 scaled by 2^19; exact for every product up to 100 * 255.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  localparam logic [31:0] CODE_POWER  = 32'hE51A52AD;
  localparam logic [31:0] CODE_PRESET = 32'hA75852AD;
  localparam logic [31:0] CODE_FWD    = 32'hBF4052AD;
  localparam logic [31:0] CODE_REV    = 32'hBE4152AD;
  localparam logic [31:0] CODE_PLUS   = 32'hF50A52AD;
  localparam logic [31:0] CODE_MINUS  = 32'hF40B52AD;
  localparam logic [31:0] CODE_RIGHT  = 32'hBC4352AD;
  localparam logic [31:0] CODE_LEFT   = 32'hBD4252AD;

  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    CFG_LOCKOUT = 3'd0,
    CFG_RELEASE = 3'd1,
    CFG_PAUSE   = 3'd2,
    CFG_STEP    = 3'd3,
    CFG_START   = 3'd4,
    CFG_PRESET  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BEEP_NONE = 3'd0,
    BEEP_ON   = 3'd1,
    BEEP_OFF  = 3'd2,
    BEEP_NO   = 3'd3,
    BEEP_ACK  = 3'd4
  } beep_t;

  typedef enum logic [1:0] {
    STEER_STOP  = 2'd0,
    STEER_RIGHT = 2'd1,
    STEER_LEFT  = 2'd2
  } steer_t;

  typedef struct packed {
    logic [15:0] lockout_ticks;
    logic [15:0] release_ticks;
    logic [15:0] pause_ticks;
    pct_t        speed_step;
    pct_t        start_speed;
    pct_t        preset_speed;
  } cfg_t;

  typedef struct packed {
    logic   power_on;
    pct_t   speed;
    logic   reverse_dir;
    steer_t steering;
    timer_t lockout_elapsed;
    timer_t steer_elapsed;
    timer_t pause_left;
  } state_t;

  typedef struct packed {
    logic  powered;
    pct_t  speed_percent;
    logic [7:0] pwm_duty;
    logic  drive_forward;
    logic  drive_reverse;
    logic  steer_right;
    logic  steer_left;
    beep_t beep;
    logic  paused;
  } res_t;

  function automatic pct_t clamp_pct(pct_t v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

  function automatic timer_t sat_inc(timer_t v);
    return (v == TIMER_MAX) ? v : v + timer_t'(1);
  endfunction

  // A 16-bit pause length cut to what the timer can hold.
  function automatic timer_t fit_timer(logic [15:0] p);
    logic [31:0] w;
    logic [31:0] m;
    w = 32'(p);
    m = 32'(TIMER_MAX);
    return (w > m) ? TIMER_MAX : w[TIMER_BITS-1:0];
  endfunction

  // speed * 255 / 100, truncated; the multiply by 255 is a shift and subtract.
  function automatic logic [7:0] duty_of(pct_t s);
    logic [14:0] prod;
    logic [27:0] q;
    prod = {s, 8'd0} - 15'(s);
    q = 28'(prod) * 28'(RECIP_100);
    return q[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

// ===== hw/rtl/rmc_in_if.sv =====
// Interface: input item channel carrying remote codes and millisecond ticks.
interface rmc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] code;
  logic        is_repeat;

  modport source (output valid, output operation, output code, output is_repeat, input ready);
  modport sink (input valid, input operation, input code, input is_repeat, output ready);
endinterface

// ===== hw/rtl/rmc_out_if.sv =====
// Interface: result item channel carrying pin levels, duty and beep code.
interface rmc_out_if;
  logic       valid;
  logic       ready;
  logic       powered;
  logic [6:0] speed_percent;
  logic [7:0] pwm_duty;
  logic       drive_forward;
  logic       drive_reverse;
  logic       steer_right;
  logic       steer_left;
  logic [2:0] beep;
  logic       paused;

  modport source (
    output valid, output powered, output speed_percent, output pwm_duty,
    output drive_forward, output drive_reverse, output steer_right,
    output steer_left, output beep, output paused, input ready
  );
  modport sink (
    input valid, input powered, input speed_percent, input pwm_duty,
    input drive_forward, input drive_reverse, input steer_right,
    input steer_left, input beep, input paused, output ready
  );
endinterface

// ===== hw/rtl/remote_motor_command_controller.sv =====
// Top level: input register, controller core and result register of the motor command block.
// An accepted item lands in the input register at the accepting edge; its state update reaches
// the result register together with the result at the edge on which the core advances, which
// waits while a full result register is not drained.
// Throughput: one item per cycle while the result consumer keeps up; back-pressure on out_ch stalls it.
// Reset (rst_n low, synchronous): power off, speed 0, forward, steering stopped, all timers 0,
// configuration back to its defaults, both pipeline stages empty.
module remote_motor_command_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  rmc_in_if.sink                         in_ch,
  rmc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [rmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rmc_pkg::*;

  cfg_t cfg;
  res_t res;

  // Input register holding one item until the core consumes it.
  logic        in_valid_r;
  logic        op_r;
  logic [31:0] code_r;
  logic        rep_r;

  // Result register; the core only advances when it can take the result.
  logic out_valid_r;
  res_t res_r;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = in_valid_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  // The input register can be refilled in the same cycle it drains, so items stream
  // back to back while the consumer keeps up.
  assign in_ch.ready = !in_valid_r || out_free;

  rmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rmc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .operation (op_r),
    .code      (code_r),
    .is_repeat (rep_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_ch.operation;
      code_r <= in_ch.code;
      rep_r  <= in_ch.is_repeat;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.powered       = res_r.powered;
  assign out_ch.speed_percent = res_r.speed_percent;
  assign out_ch.pwm_duty      = res_r.pwm_duty;
  assign out_ch.drive_forward = res_r.drive_forward;
  assign out_ch.drive_reverse = res_r.drive_reverse;
  assign out_ch.steer_right   = res_r.steer_right;
  assign out_ch.steer_left    = res_r.steer_left;
  assign out_ch.beep          = res_r.beep;
  assign out_ch.paused        = res_r.paused;
endmodule

// ===== hw/rtl/rmc_cfg_regs.sv =====
// Configuration register file with reset defaults and an indexed write port.
module rmc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [rmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output rmc_pkg::cfg_t                  cfg
);
  import rmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LOCKOUT: cfg_nxt.lockout_ticks = cfg_data;
        CFG_RELEASE: cfg_nxt.release_ticks = cfg_data;
        CFG_PAUSE:   cfg_nxt.pause_ticks = cfg_data;
        CFG_STEP:    cfg_nxt.speed_step = cfg_data[6:0];
        CFG_START:   cfg_nxt.start_speed = cfg_data[6:0];
        CFG_PRESET:  cfg_nxt.preset_speed = cfg_data[6:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ticks <= 16'd500;
      cfg_r.release_ticks <= 16'd150;
      cfg_r.pause_ticks   <= 16'd2000;
      cfg_r.speed_step    <= 7'd10;
      cfg_r.start_speed   <= 7'd15;
      cfg_r.preset_speed  <= 7'd30;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== hw/rtl/rmc_core.sv =====
// Controller state and its single-pass update for one code or tick item.
module rmc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          operation,
  input  logic [31:0]   code,
  input  logic          is_repeat,
  input  rmc_pkg::cfg_t cfg,
  output rmc_pkg::res_t res
);
  import rmc_pkg::*;

  state_t st_r;
  state_t st_nxt;
  beep_t  beep;
  logic   want_rev;
  logic   is_dir;
  logic   paused;
  logic   drive_on;
  logic [7:0] sum;
  steer_t dir;

  always_comb begin
    st_nxt   = st_r;
    beep     = BEEP_NONE;
    sum      = {1'b0, st_r.speed} + {1'b0, cfg.speed_step};
    is_dir   = (code == CODE_FWD) || (code == CODE_REV);
    want_rev = (code == CODE_REV);
    dir      = (code == CODE_RIGHT) ? STEER_RIGHT : STEER_LEFT;

    if (operation) begin
      // Tick: the pause counts down, otherwise the lockout counts up.
      if (st_r.pause_left != '0) begin
        st_nxt.pause_left = st_r.pause_left - timer_t'(1);
      end else begin
        st_nxt.lockout_elapsed = sat_inc(st_r.lockout_elapsed);
      end
      st_nxt.steer_elapsed = sat_inc(st_r.steer_elapsed);
      if (st_r.steering != STEER_STOP &&
          32'(st_nxt.steer_elapsed) > 32'(cfg.release_ticks)) begin
        st_nxt.steering = STEER_STOP;
      end
    end else if (st_r.pause_left == '0) begin
      if (code == CODE_POWER) begin
        if (!is_repeat) begin
          if (!st_r.power_on) begin
            st_nxt.power_on    = 1'b1;
            st_nxt.speed       = clamp_pct(cfg.start_speed);
            st_nxt.reverse_dir = 1'b0;
            beep               = BEEP_ON;
          end else begin
            st_nxt.power_on = 1'b0;
            st_nxt.steering = STEER_STOP;
            st_nxt.speed    = '0;
            beep            = BEEP_OFF;
          end
        end
      end else if (st_r.power_on) begin
        if (code == CODE_RIGHT || code == CODE_LEFT) begin
          // Steering codes are honored on repeat frames to hold the steering.
          beep                 = (st_r.steering != dir) ? BEEP_ACK : BEEP_NONE;
          st_nxt.steering      = dir;
          st_nxt.steer_elapsed = '0;
        end else if (!is_repeat) begin
          if (code == CODE_PRESET) begin
            if (st_r.speed == clamp_pct(cfg.preset_speed)) begin
              beep = BEEP_NO;
            end else begin
              st_nxt.speed = clamp_pct(cfg.preset_speed);
              beep         = BEEP_ACK;
            end
          end else if (code == CODE_PLUS) begin
            if (st_r.speed >= PCT_MAX) begin
              beep = BEEP_NO;
            end else begin
              st_nxt.speed = (sum > {1'b0, PCT_MAX}) ? PCT_MAX : sum[6:0];
              beep         = BEEP_ACK;
            end
          end else if (code == CODE_MINUS) begin
            if (st_r.speed == '0) begin
              beep = BEEP_NO;
            end else begin
              st_nxt.speed = (st_r.speed > cfg.speed_step) ?
                             st_r.speed - cfg.speed_step : '0;
              beep         = BEEP_ACK;
            end
          end else if (is_dir) begin
            if (st_r.reverse_dir == want_rev) begin
              beep = BEEP_NONE;
            end else if (32'(st_r.lockout_elapsed) < 32'(cfg.lockout_ticks)) begin
              beep = BEEP_NO;
            end else begin
              st_nxt.reverse_dir     = want_rev;
              st_nxt.speed           = clamp_pct(cfg.start_speed);
              st_nxt.pause_left      = fit_timer(cfg.pause_ticks);
              st_nxt.lockout_elapsed = '0;
              beep                   = BEEP_ACK;
            end
          end
        end
      end
    end

    paused   = (st_nxt.pause_left != '0);
    drive_on = !paused && (st_nxt.speed != '0);

    res.powered       = st_nxt.power_on;
    res.speed_percent = st_nxt.speed;
    res.pwm_duty      = paused ? 8'd0 : duty_of(st_nxt.speed);
    res.drive_forward = drive_on && !st_nxt.reverse_dir;
    res.drive_reverse = drive_on && st_nxt.reverse_dir;
    res.steer_right   = (st_nxt.steering == STEER_RIGHT);
    res.steer_left    = (st_nxt.steering == STEER_LEFT);
    res.beep          = beep;
    res.paused        = paused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.power_on        <= 1'b0;
      st_r.speed           <= '0;
      st_r.reverse_dir     <= 1'b0;
      st_r.steering        <= STEER_STOP;
      st_r.lockout_elapsed <= '0;
      st_r.steer_elapsed   <= '0;
      st_r.pause_left      <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end
endmodule
